// ----- rtl/rwa_pkg.sv -----
// ----------------------------------------------------------------------------
// rwa_pkg: shared types and constants of the running window average unit
// Fixed field widths and the opcode set of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package rwa_pkg;

  // Width of the window length register and of the samples-held count.
  localparam int unsigned LEN_BITS = 5;

  // Width of the average result field.
  localparam int unsigned AVG_BITS = 16;

  // Window length after reset, before saturation to the ring depth.
  localparam int unsigned LEN_RESET = 16;

  // Operation of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

endpackage : rwa_pkg

// ----- rtl/running_window_average_unit.sv -----
// ----------------------------------------------------------------------------
// running_window_average_unit: moving average over the last N samples
// Ring of recent samples, running sum and a bit-serial divider by the count.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid_i / sample_ready_o / sample_i): one beat per
//   sample. The unit takes a beat only while its sequencer is idle.
//   result channel (result_valid_o / result_ready_i / average_o,
//   window_full_o): one beat per sample, the truncated mean of the samples
//   held and a flag that is set once the window has filled.
//   window_length channel: writes the number of samples averaged (0 acts as
//   1, values above RING_DEPTH saturate) and restarts accumulation. It is
//   taken only while the sequencer is idle.
// Sequence: a sample beat is followed by the ring read, the subtract of the
//   leaving sample and the add of the new one, then the restoring division,
//   which runs SAMPLE_BITS + 5 steps through the one shared add/subtract
//   unit. The next sample is taken only once the result has gone to the
//   output register.
// Stall: a finished result sits in the output register; the unit takes the
//   next sample meanwhile and holds the following result until the first is
//   taken.
// Reset: sum, count and write position clear, window length goes to 16 (or
//   RING_DEPTH if smaller). The ring itself is not cleared: an entry is read
//   back only after it was written since the last restart.
// ----------------------------------------------------------------------------
module running_window_average_unit #(
  parameter int unsigned RING_DEPTH  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          window_length_valid_i,
  output logic                          window_length_ready_o,
  input  logic [rwa_pkg::LEN_BITS-1:0]  window_length_i,
  // sample channel
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  // result channel
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [rwa_pkg::AVG_BITS-1:0]  average_o,
  output logic                          window_full_o
);

  localparam int unsigned LW     = rwa_pkg::LEN_BITS;
  localparam int unsigned AVW    = rwa_pkg::AVG_BITS;
  // Sum of up to 31 samples never overflows this width.
  localparam int unsigned SUM_W  = SAMPLE_BITS + LW;
  localparam int unsigned PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CMP_W  = ((PTR_W > LW) ? PTR_W : LW) + 1;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned RST_LEN =
    (RING_DEPTH < rwa_pkg::LEN_RESET) ? RING_DEPTH : rwa_pkg::LEN_RESET;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a sample beat
  localparam logic [2:0] ST_READ = 3'd1;  // read leaving sample from the ring
  localparam logic [2:0] ST_SUB  = 3'd2;  // drop leaving sample from the sum
  localparam logic [2:0] ST_ADD  = 3'd3;  // add new sample, write ring
  localparam logic [2:0] ST_DIV  = 3'd4;  // one quotient bit per cycle
  localparam logic [2:0] ST_PUSH = 3'd5;  // hand result to output register

  logic [2:0]             state_q, state_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [LW-1:0]          held_q, held_d;
  logic [LW-1:0]          len_q, len_d;
  logic [PTR_W-1:0]       pos_q, pos_d;
  logic [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [SUM_W-1:0]       quo_q, quo_d;
  logic [LW-1:0]          rem_q, rem_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   full_q, full_d;
  logic                   out_valid_q, out_valid_d;
  logic [AVW-1:0]         avg_q, avg_d;
  logic                   out_full_q, out_full_d;

  // Shared unit hookup.
  rwa_pkg::alu_op_e       alu_op;
  logic [SUM_W-1:0]       alu_a, alu_b, alu_res;
  logic                   alu_borrow;

  // Ring hookup.
  logic                   ring_we;
  logic [SAMPLE_BITS-1:0] ring_rdata;

  logic                   in_fire, cfg_fire, out_load;
  logic [LW:0]            rem_sh;
  logic [CMP_W-1:0]       pos_inc;
  logic [LW-1:0]          held_inc;
  logic [SUM_W+AVW-1:0]   quo_ext;

  // Saturate the written window length into 1 .. RING_DEPTH.
  function automatic logic [LW-1:0] eff_len(input logic [LW-1:0] wl);
    logic [LW-1:0] len;
    len = wl;
    if (wl == '0) begin
      len = LW'(1);
    end else if (int'(wl) > int'(RING_DEPTH)) begin
      len = LW'(RING_DEPTH);
    end
    return len;
  endfunction

  rwa_alu #(
    .W (SUM_W)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  rwa_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SAMPLE_BITS),
    .AW    (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (pos_q),
    .wdata_i (smp_q),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  assign sample_ready_o        = (state_q == ST_IDLE);
  assign window_length_ready_o = (state_q == ST_IDLE);
  assign in_fire               = sample_valid_i && sample_ready_o;
  assign cfg_fire              = window_length_valid_i && window_length_ready_o;

  // Partial remainder shifted left with the next dividend bit.
  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign pos_inc  = CMP_W'(pos_q) + CMP_W'(1);
  assign held_inc = (held_q < len_q) ? held_q + LW'(1) : held_q;
  assign quo_ext  = {{AVW{1'b0}}, quo_q};
  assign out_load = (state_q == ST_PUSH) && (!out_valid_q || result_ready_i);

  // Steer the shared unit by sequencer state.
  always_comb begin
    alu_op = rwa_pkg::ALU_ADD;
    alu_a  = sum_q;
    alu_b  = SUM_W'(smp_q);
    case (state_q)
      ST_SUB: begin
        alu_op = rwa_pkg::ALU_SUB;
        alu_b  = SUM_W'(ring_rdata);
      end
      ST_DIV: begin
        alu_op = rwa_pkg::ALU_SUB;
        alu_a  = SUM_W'(rem_sh);
        alu_b  = SUM_W'(held_q);
      end
      default: begin
        alu_op = rwa_pkg::ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    held_d      = held_q;
    len_d       = len_q;
    pos_d       = pos_q;
    smp_d       = smp_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    full_d      = full_q;
    ring_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          smp_d   = sample_i;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        // Window full: the entry at the write position leaves.
        if (held_q >= len_q) begin
          sum_d = alu_res;
        end
        state_d = ST_ADD;
      end
      ST_ADD: begin
        sum_d   = alu_res;
        quo_d   = alu_res;
        rem_d   = '0;
        step_d  = STEP_W'(SUM_W - 1);
        held_d  = held_inc;
        full_d  = (held_inc >= len_q);
        ring_we = 1'b1;
        if (pos_inc >= CMP_W'(len_q)) begin
          pos_d = '0;
        end else begin
          pos_d = PTR_W'(pos_inc);
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (alu_borrow) begin
          rem_d = LW'(rem_sh);
        end else begin
          rem_d = LW'(alu_res);
        end
        quo_d = {quo_q[SUM_W-2:0], ~alu_borrow};
        if (step_q == '0) begin
          state_d = ST_PUSH;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // Restart accumulation on a window length write.
    if (cfg_fire) begin
      len_d  = eff_len(window_length_i);
      sum_d  = '0;
      held_d = '0;
      pos_d  = '0;
    end
  end

  // Output register: load a finished result, drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    avg_d       = avg_q;
    out_full_d  = out_full_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      avg_d       = quo_ext[AVW-1:0];
      out_full_d  = full_q;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      held_q      <= '0;
      len_q       <= LW'(RST_LEN);
      pos_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      held_q      <= held_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    full_q     <= full_d;
    avg_q      <= avg_d;
    out_full_q <= out_full_d;
  end

  assign result_valid_o = out_valid_q;
  assign average_o      = avg_q;
  assign window_full_o  = out_full_q;

`ifndef SYNTHESIS
  // A sample beat always starts the ring read.
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_READ))
    else $error("sample beat did not start the ring read");

  // Held count never exceeds the window.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= len_q)
    else $error("samples held exceed window length");

  // Write position stays inside the window.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(pos_q) < CMP_W'(len_q))
    else $error("write position outside window");

  // Partial remainder stays below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((held_q != '0) && (rem_q < held_q)))
    else $error("divider remainder out of range");

  // A waiting result is never overwritten before it is taken.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_ready_i) |=> result_valid_o && $stable(average_o))
    else $error("pending result lost");
`endif

endmodule : running_window_average_unit

// ----- rtl/rwa_ring.sv -----
// ----------------------------------------------------------------------------
// rwa_ring: sample ring store
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rwa_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : rwa_ring

// ----- rtl/rwa_alu.sv -----
// ----------------------------------------------------------------------------
// rwa_alu: shared add/subtract unit
// Serves the running sum update and every step of the restoring division.
// ----------------------------------------------------------------------------
module rwa_alu #(
  parameter int unsigned W = 21
) (
  input  rwa_pkg::alu_op_e op_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [W-1:0]     res_o,
  output logic             borrow_o
);

  logic [W:0] full;

  always_comb begin
    case (op_i)
      rwa_pkg::ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      rwa_pkg::ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default:          full = {1'b0, a_i};
    endcase
  end

  // Top bit is the carry on add, the borrow (a < b) on subtract.
  assign res_o    = full[W-1:0];
  assign borrow_o = full[W];

endmodule : rwa_alu
